FILE: src/kcl_pkg.sv
// shared types, constants and lookup tables for the keypad code lock display unit
// no dependencies; imported by the scanner, lock, display and top modules
`default_nettype none

package kcl_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_UNLOCK_CODE = 2'd0;
	localparam logic [1:0] REG_SCAN_GAP    = 2'd1;
	localparam logic [1:0] REG_DOOR_OPEN   = 2'd2;

	// configuration reset values
	localparam logic [15:0] UNLOCK_CODE_RST = 16'h1234;
	localparam logic [7:0]  SCAN_GAP_RST    = 8'd20;
	localparam logic [15:0] DOOR_OPEN_RST   = 16'd10000;

	// key found by a scan that follows a scan without a key
	typedef struct packed {
		logic       valid;
		logic [3:0] code;
	} key_evt_t;

	// door status for the result register
	typedef struct packed {
		logic release_on;
		logic accepted;
	} door_stat_t;

	// seven-segment patterns, segments a..g in bits 7..1, point in bit 0
	localparam logic [7:0] SEG_TABLE [16] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
		8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
	};

	// key code by column and row
	localparam logic [3:0] KEY_TABLE [4][4] = '{
		'{4'd1,  4'd2, 4'd3,  4'd10},
		'{4'd4,  4'd5, 4'd6,  4'd11},
		'{4'd7,  4'd8, 4'd9,  4'd12},
		'{4'd14, 4'd0, 4'd15, 4'd13}
	};

	// single row picks its index, anything else reads as row 0
	function automatic logic [1:0] row_index(input logic [3:0] rows);
		logic [1:0] idx;
		unique case (rows)
			4'b0010: idx = 2'd1;
			4'b0100: idx = 2'd2;
			4'b1000: idx = 2'd3;
			default: idx = 2'd0;
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: src/kcl_scan.sv
// keypad column scanner with inter-scan gap and new-key detection
// depends on kcl_pkg
`default_nettype none

module kcl_scan (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [3:0]      rows,
	input  wire logic [7:0]      scan_gap,
	output logic [3:0]           col_drive,
	output kcl_pkg::key_evt_t    key_evt
);
	import kcl_pkg::*;

	logic [1:0] scan_column_q;
	logic [7:0] gap_counter_q;
	logic       last_key_q;

	logic [1:0] column_d;
	logic [7:0] gap_d;
	logic       last_key_d;
	logic [7:0] gap_dec;
	logic       found;
	logic       scan_end;

	// column currently driven, also held through the gap
	assign col_drive = 4'b0001 << scan_column_q;

	assign gap_dec  = gap_counter_q - 8'd1;
	assign found    = (rows != 4'd0);
	assign scan_end = found || (scan_column_q == 2'd3);

	// next scan state for this tick
	always_comb begin
		column_d       = scan_column_q;
		gap_d          = gap_counter_q;
		last_key_d     = last_key_q;
		key_evt.valid  = 1'b0;
		key_evt.code   = KEY_TABLE[scan_column_q][row_index(rows)];
		if (gap_counter_q != 8'd0) begin
			gap_d = gap_dec;
			if (gap_dec == 8'd0) begin
				column_d = 2'd0;
			end
		end else if (scan_end) begin
			key_evt.valid = found && !last_key_q;
			last_key_d    = found;
			gap_d         = scan_gap;
			if (scan_gap == 8'd0) begin
				column_d = 2'd0;
			end
		end else begin
			column_d = scan_column_q + 2'd1;
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_column_q <= 2'd0;
			gap_counter_q <= 8'd0;
			last_key_q    <= 1'b0;
		end else if (step) begin
			scan_column_q <= column_d;
			gap_counter_q <= gap_d;
			last_key_q    <= last_key_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/kcl_lock.sv
// digit store, code compare and door release timer
// depends on kcl_pkg
`default_nettype none

module kcl_lock (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire kcl_pkg::key_evt_t key_evt,
	input  wire logic [15:0]       unlock_code,
	input  wire logic [15:0]       door_open,
	output logic [15:0]            digits_next,
	output kcl_pkg::door_stat_t    door_stat
);
	import kcl_pkg::*;

	// newest key in bits 3..0, oldest in bits 15..12
	logic [15:0] digits_q;
	logic [15:0] door_counter_q;
	logic        door_pending_q;

	logic [15:0] shifted;
	logic        match;
	logic        accept_now;
	logic [15:0] open_time;
	logic [15:0] door_d;
	logic        pending_d;
	logic [15:0] door_mid;
	logic [15:0] door_dec;

	assign shifted   = {digits_q[11:0], key_evt.code};
	assign match     = (shifted == unlock_code);
	assign open_time = (door_open == 16'd0) ? 16'd1 : door_open;

	// digit store update, cleared on a match
	always_comb begin
		digits_next = digits_q;
		if (key_evt.valid) begin
			digits_next = match ? 16'd0 : shifted;
		end
	end

	assign accept_now = key_evt.valid && match;

	// door timer with one queued opening
	always_comb begin
		door_mid  = door_counter_q;
		pending_d = door_pending_q;
		door_stat.accepted = accept_now;
		if (accept_now) begin
			if (door_counter_q == 16'd0) begin
				door_mid = open_time;
			end else begin
				pending_d = 1'b1;
			end
		end
		door_stat.release_on = (door_mid != 16'd0);
		door_dec = door_mid - 16'd1;
		door_d   = door_mid;
		if (door_mid != 16'd0) begin
			door_d = door_dec;
			if (door_dec == 16'd0 && pending_d) begin
				door_d    = open_time;
				pending_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q       <= 16'd0;
			door_counter_q <= 16'd0;
			door_pending_q <= 1'b0;
		end else if (step) begin
			digits_q       <= digits_next;
			door_counter_q <= door_d;
			door_pending_q <= pending_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/kcl_display.sv
// multiplexed four-digit seven-segment driver
// depends on kcl_pkg
`default_nettype none

module kcl_display (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [15:0] digits,
	output logic [7:0]       seg,
	output logic [3:0]       strobe
);
	import kcl_pkg::*;

	logic [1:0] display_index_q;
	logic [3:0] nibble;

	// digit 0 shows the newest key
	assign nibble = digits[{display_index_q, 2'b00} +: 4];
	assign seg    = SEG_TABLE[nibble];
	assign strobe = 4'b0001 << display_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_index_q <= 2'd0;
		end else if (step) begin
			display_index_q <= display_index_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

FILE: src/keypad_code_lock_display_unit.sv
// Keypad code lock with seven-segment display, top level.
// One input transfer is one tick: row_lines sensed for the column driven on
// that tick. Every tick gives exactly one result transfer carrying the column
// driven, the strobed display digit and its segments, the door release and a
// code-accepted pulse.
// Input transfers land in an input register; the next cycle in which the
// result register is free or being emptied runs the tick update (scanner,
// digit store and door timer, display mux) and loads the result register.
// Each tick passes through the input register and then the result register;
// one tick is taken every cycle while the output is not stalled.
// A stalled result holds its payload; the input register then fills and
// in_stall rises until the result is taken, so no tick is lost.
// Configuration: cfg_we with cfg_index 0 (unlock code), 1 (scan gap),
// 2 (door open ticks); index 3 is ignored. Write only while idle.
// Reset clears the scanner, lock and display state, loads default
// configuration and empties both registers.
// depends on kcl_pkg, kcl_scan, kcl_lock, kcl_display
`default_nettype none

module keypad_code_lock_display_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  row_lines,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       column_drive,
	output logic [7:0]       segment_pattern,
	output logic [3:0]       digit_strobe,
	output logic             door_release,
	output logic             code_accepted,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import kcl_pkg::*;

	logic [15:0] unlock_code_q;
	logic [7:0]  scan_gap_q;
	logic [15:0] door_open_q;

	logic        valid_s1;
	logic [3:0]  rows_s1;
	logic        out_valid_q;
	logic [3:0]  column_q;
	logic [7:0]  seg_q;
	logic [3:0]  strobe_q;
	logic        release_q;
	logic        accepted_q;

	logic        advance;
	logic        step;
	logic        in_xfer;
	logic [3:0]  col_drive;
	key_evt_t    key_evt;
	logic [15:0] digits_next;
	door_stat_t  door_stat;
	logic [7:0]  seg;
	logic [3:0]  strobe;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlock_code_q <= UNLOCK_CODE_RST;
			scan_gap_q    <= SCAN_GAP_RST;
			door_open_q   <= DOOR_OPEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNLOCK_CODE: unlock_code_q <= cfg_data;
				REG_SCAN_GAP:    scan_gap_q    <= cfg_data[7:0];
				REG_DOOR_OPEN:   door_open_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake control
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rows_s1 <= row_lines;
		end
	end

	kcl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rows      (rows_s1),
		.scan_gap  (scan_gap_q),
		.col_drive (col_drive),
		.key_evt   (key_evt)
	);

	kcl_lock u_lock (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.key_evt     (key_evt),
		.unlock_code (unlock_code_q),
		.door_open   (door_open_q),
		.digits_next (digits_next),
		.door_stat   (door_stat)
	);

	kcl_display u_display (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.digits (digits_next),
		.seg    (seg),
		.strobe (strobe)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			column_q   <= col_drive;
			seg_q      <= seg;
			strobe_q   <= strobe;
			release_q  <= door_stat.release_on;
			accepted_q <= door_stat.accepted;
		end
	end

	assign out_valid       = out_valid_q;
	assign column_drive    = column_q;
	assign segment_pattern = seg_q;
	assign digit_strobe    = strobe_q;
	assign door_release    = release_q;
	assign code_accepted   = accepted_q;

endmodule

`default_nettype wire

FILE: src/kcl_checker.sv
// port-level checks for the keypad code lock display unit, bound to the top
// depends on keypad_code_lock_display_unit
`default_nettype none

module kcl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [3:0] column_drive,
	input wire logic [7:0] segment_pattern,
	input wire logic [3:0] digit_strobe,
	input wire logic       door_release,
	input wire logic       code_accepted
);

	// stalled result keeps its segments, strobe and column
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segment_pattern)
			&& $stable(digit_strobe) && $stable(column_drive))
		else $error("stalled result changed");

	// exactly one display digit strobed
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(digit_strobe))
		else $error("digit strobe not one-hot");

	// exactly one keypad column driven
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(column_drive))
		else $error("column drive not one-hot");

	// an accepted code always opens the door on the same tick
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_accepted |-> door_release)
		else $error("code accepted without door release");

endmodule

bind keypad_code_lock_display_unit kcl_checker u_kcl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.column_drive    (column_drive),
	.segment_pattern (segment_pattern),
	.digit_strobe    (digit_strobe),
	.door_release    (door_release),
	.code_accepted   (code_accepted)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for keypad_code_lock_display_unit: keypad scan, code entry,
// door timer and display multiplexing, checked against an in-bench tick predictor.
// Depends on kcl_pkg (register indexes) and the RTL under src/.
`timescale 1ns / 1ps

module tb_top;
	import kcl_pkg::REG_UNLOCK_CODE;
	import kcl_pkg::REG_SCAN_GAP;
	import kcl_pkg::REG_DOOR_OPEN;

	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         STALL_LIMIT = 2000;

	// key codes by column and row, and segment patterns by digit value
	localparam logic [3:0] KEY_MAP [4][4] = '{
		'{4'd1,  4'd2, 4'd3,  4'd10},
		'{4'd4,  4'd5, 4'd6,  4'd11},
		'{4'd7,  4'd8, 4'd9,  4'd12},
		'{4'd14, 4'd0, 4'd15, 4'd13}
	};
	localparam logic [7:0] SEG_MAP [16] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
		8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
	};

	typedef struct packed {
		logic [3:0] column;
		logic [7:0] segments;
		logic [3:0] strobe;
		logic       door_open;
		logic       accepted;
	} tick_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  row_lines = 4'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  column_drive;
	logic [7:0]  segment_pattern;
	logic [3:0]  digit_strobe;
	logic        door_release;
	logic        code_accepted;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_UNLOCK_CODE;
	logic [15:0] cfg_data = 16'h0000;

	// predicted lock state and configuration
	logic [15:0] code_cfg = 16'h1234;
	logic [7:0]  gap_cfg = 8'd20;
	logic [15:0] open_cfg = 16'd10000;
	logic [1:0]  scan_col = 2'd0;
	logic [7:0]  gap_left = 8'd0;
	logic        prev_scan_key = 1'b0;
	logic [3:0]  digits [4] = '{default: 4'h0};
	logic [1:0]  disp_idx = 2'd0;
	logic [15:0] door_left = 16'd0;
	logic        door_queued = 1'b0;

	tick_result_t tick_results [$];
	int           mismatches = 0;
	int           ticks_sent = 0;
	int           idle_cycles = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	keypad_code_lock_display_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.row_lines(row_lines),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.column_drive(column_drive),
		.segment_pattern(segment_pattern),
		.digit_strobe(digit_strobe),
		.door_release(door_release),
		.code_accepted(code_accepted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one tick of the lock: scan, key entry and match, door timer, display
	function automatic tick_result_t lock_tick(input logic [3:0] rows);
		tick_result_t r;
		logic         found;
		logic         scan_done;
		logic         match;
		logic [3:0]   key;
		logic [1:0]   row;
		logic [15:0]  span;
		r = '0;
		found = 1'b0;
		scan_done = 1'b0;
		match = 1'b0;
		key = 4'h0;
		row = 2'd0;
		span = (open_cfg == 16'd0) ? 16'd1 : open_cfg;
		r.column = 4'b0001 << scan_col;
		if (gap_left != 8'd0) begin
			gap_left--;
			if (gap_left == 8'd0)
				scan_col = 2'd0;
		end else begin
			if (rows != 4'h0) begin
				case (rows)
					4'b0010: row = 2'd1;
					4'b0100: row = 2'd2;
					4'b1000: row = 2'd3;
					default: row = 2'd0;
				endcase
				key = KEY_MAP[scan_col][row];
				found = 1'b1;
				scan_done = 1'b1;
			end else if (scan_col == 2'd3) begin
				scan_done = 1'b1;
			end else begin
				scan_col++;
			end
			if (scan_done) begin
				// a key counts only after a scan that saw none
				if (found && !prev_scan_key) begin
					digits = '{digits[1], digits[2], digits[3], key};
					if ({digits[0], digits[1], digits[2], digits[3]} == code_cfg) begin
						digits = '{default: 4'h0};
						match = 1'b1;
					end
				end
				prev_scan_key = found;
				gap_left = gap_cfg;
				if (gap_cfg == 8'd0)
					scan_col = 2'd0;
			end
		end
		// door timer with one queued opening at most
		if (match) begin
			if (door_left == 16'd0)
				door_left = span;
			else
				door_queued = 1'b1;
		end
		r.door_open = (door_left != 16'd0);
		if (door_left != 16'd0) begin
			door_left--;
			if (door_left == 16'd0 && door_queued) begin
				door_left = span;
				door_queued = 1'b0;
			end
		end
		r.segments = SEG_MAP[digits[2'd3 - disp_idx]];
		r.strobe = 4'b0001 << disp_idx;
		r.accepted = match;
		disp_idx++;
		return r;
	endfunction

	// rows a held key shows for the column currently driven
	function automatic logic [3:0] rows_for_key(input logic [3:0] key);
		logic [3:0] rows;
		rows = 4'h0;
		for (int r = 0; r < 4; r++)
			if (KEY_MAP[scan_col][r] == key)
				rows = 4'b0001 << r;
		return rows;
	endfunction

	// one input transfer, with random idle cycles ahead of it
	task automatic send_tick(input logic [3:0] rows);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		row_lines <= rows;
		tick_results.push_back(lock_tick(rows));
		ticks_sent++;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// release, press until a scan sees the key, then hold a little longer
	task automatic tap_key(input logic [3:0] key, input int extra);
		while (prev_scan_key)
			send_tick(4'h0);
		do
			send_tick(rows_for_key(key));
		while (!prev_scan_key);
		repeat (extra)
			send_tick(rows_for_key(key));
	endtask

	task automatic enter_digits(input logic [15:0] code, input int count);
		for (int i = 3; i > 3 - count; i--)
			tap_key(code[4*i +: 4], $urandom_range(0, 2));
	endtask

	// stop sending and wait until every predicted result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		while (tick_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] code, input logic [7:0] gap,
			input logic [15:0] span);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_UNLOCK_CODE;
		cfg_data <= code;
		@(posedge clk);
		cfg_index <= REG_SCAN_GAP;
		cfg_data <= {8'h00, gap};
		@(posedge clk);
		cfg_index <= REG_DOOR_OPEN;
		cfg_data <= span;
		@(posedge clk);
		// unused index must leave everything alone
		cfg_index <= REG_UNUSED;
		cfg_data <= 16'($urandom_range(65535));
		@(posedge clk);
		cfg_we <= 1'b0;
		code_cfg = code;
		gap_cfg = gap;
		open_cfg = span;
	endtask

	// default settings: empty scans, single rows, several rows, gap ignoring rows
	task automatic test_idle_scan();
		repeat (3) send_tick(4'h0);
		send_tick(4'h8);
		for (int i = 0; i < 16; i++)
			send_tick(4'(i));
		repeat (6) send_tick(4'hF);
	endtask

	// every key once, rows pressed together, one key held over many scans
	task automatic test_every_key();
		write_config(16'hABCD, 8'd0, 16'd3);
		for (int k = 0; k < 16; k++)
			tap_key(4'(k), 0);
		send_tick(4'b0110);
		send_tick(4'b1111);
		send_tick(4'b0101);
		tap_key(4'h7, 20);
	endtask

	// near miss, match, matches while open, zero door time
	task automatic test_code_entry();
		write_config(16'h1234, 8'd0, 16'd40);
		enter_digits(16'h1235, 4);
		repeat (3) enter_digits(16'h1234, 4);
		while (door_left != 16'd0 || door_queued)
			send_tick(4'h0);
		write_config(16'h1234, 8'd0, 16'd0);
		enter_digits(16'h1234, 4);
		repeat (4) send_tick(4'h0);
	endtask

	// mostly real code entry with random timing, plus stray keys and noise
	task automatic test_random_use(input int items, input int send_pct, input int recv_pct);
		int target;
		int pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (2) begin
			write_config(16'($urandom_range(65535)),
				($urandom_range(9) == 0) ? 8'($urandom_range(8, 30)) : 8'($urandom_range(0, 3)),
				16'($urandom_range(1, 60)));
			target = ticks_sent + items / 2;
			while (ticks_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 50)
					enter_digits(code_cfg, 4);
				else if (pick < 65)
					enter_digits(code_cfg, $urandom_range(1, 3));
				else if (pick < 85)
					tap_key(4'($urandom_range(15)), $urandom_range(0, 4));
				else if (pick < 95)
					repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(15)));
				else
					settle();
			end
		end
	endtask

	// longest gap, longest door time, all-ones and all-zero codes
	task automatic test_extremes();
		write_config(16'hFFFF, 8'd255, 16'd65535);
		tap_key(4'hF, 3);
		while (prev_scan_key)
			send_tick(4'h0);
		write_config(16'hFFFF, 8'd0, 16'd65535);
		enter_digits(16'hFFFF, 4);
		write_config(16'h0000, 8'd0, 16'd1);
		enter_digits(16'h0000, 4);
		repeat (8) send_tick(4'($urandom_range(15)));
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
	endtask

	// random back-pressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_results.size() == 0) begin
				report_mismatch("unexpected result", 8'h00, 8'h00);
			end else begin
				want = tick_results.pop_front();
				if (column_drive !== want.column)
					report_mismatch("column_drive", 8'(want.column), 8'(column_drive));
				if (segment_pattern !== want.segments)
					report_mismatch("segment_pattern", want.segments, segment_pattern);
				if (digit_strobe !== want.strobe)
					report_mismatch("digit_strobe", 8'(want.strobe), 8'(digit_strobe));
				if (door_release !== want.door_open)
					report_mismatch("door_release", 8'(want.door_open), 8'(door_release));
				if (code_accepted !== want.accepted)
					report_mismatch("code_accepted", 8'(want.accepted), 8'(code_accepted));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[keypad_code_lock_display_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 31;
		recv_idle_pct = 71;
		test_idle_scan();
		test_every_key();
		test_code_entry();
		test_random_use(450, 31, 71);
		test_random_use(450, 71, 31);
		test_random_use(350, 0, 0);
		test_extremes();
		settle();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && tick_results.size() == 0)
			$display("[keypad_code_lock_display_unit] OK");
		else
			$display("[keypad_code_lock_display_unit] ERROR");
		$finish;
	end

endmodule
